// ===== hdl/r3d_pkg.sv =====
// Shared types and constants for the disparity-to-3D reprojection block.
// Used by every module under hdl/; depends on nothing.
package r3d_pkg;

	// Field widths
	localparam int CFG_W     = 32;            // Q16.16 matrix terms
	localparam int DISP_W    = 16;            // Q12.4 disparity
	localparam int PIX_W     = 12;            // column / row index
	localparam int OUT_W     = 48;            // Q32.16 point coordinates
	localparam int FRAC_W    = 16;            // fraction bits of Q16.16 / Q32.16
	localparam int DISP_FRAC = 4;             // fraction bits of the disparity

	// Internal widths
	localparam int W_W       = 48;            // signed weight, 20 fraction bits
	localparam int N_W       = 34;            // signed numerator, Q.16
	localparam int AN_W      = 33;            // numerator magnitude
	localparam int SCALE_SH  = 21;            // 2^20 scale plus the doubling for rounding
	localparam int NN_W      = AN_W + SCALE_SH; // rounded dividend 2*|N|*2^20 + |W|
	localparam int DVS_W     = W_W + 1;       // divisor 2*|W|
	localparam int Q_W       = OUT_W;         // quotient bits resolved by the divider
	localparam int HI_W      = NN_W - Q_W;    // dividend bits above the quotient range
	localparam int DIV_STEPS = Q_W;           // one quotient bit per stage

	localparam int NUM_LANES = 3;
	localparam int LANE_X    = 0;
	localparam int LANE_Y    = 1;
	localparam int LANE_Z    = 2;

	localparam int MAX_SIDE_DEF = 4096;

	// 1.0 in Q16.16
	localparam logic [CFG_W-1:0] ONE_Q16 = 32'h0001_0000;

	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Configuration register map
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_OFFSET    = 3'd0,
		CFG_Y_OFFSET    = 3'd1,
		CFG_FOCAL_TERM  = 3'd2,
		CFG_DISP_SCALE  = 3'd3,
		CFG_DISP_OFFSET = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] x_offset;
		logic signed [CFG_W-1:0] y_offset;
		logic signed [CFG_W-1:0] focal_term;
		logic signed [CFG_W-1:0] disp_scale;
		logic signed [CFG_W-1:0] disp_offset;
	} cfg_t;

	// Channel payloads
	typedef struct packed {
		logic signed [DISP_W-1:0] disparity;
		logic [PIX_W-1:0]         col;
		logic [PIX_W-1:0]         row;
	} pixel_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] point_x;
		logic signed [OUT_W-1:0] point_y;
		logic signed [OUT_W-1:0] point_z;
		logic                    invalid;
	} point_t;

	// Divider pipeline payload: one lane per coordinate, shared divisor
	typedef struct packed {
		logic [DVS_W-1:0] rem;   // partial remainder
		logic [Q_W-1:0]   nq;    // dividend bits out at the top, quotient bits in at the bottom
		logic             neg;   // result sign
		logic             ovf;   // quotient at or above 2^Q_W
	} lane_t;

	typedef struct packed {
		logic                        bad;  // zero weight or coordinate outside the image
		logic [DVS_W-1:0]            dvs;
		lane_t [NUM_LANES-1:0]       lane;
	} div_t;

endpackage

// ===== hdl/r3d_front.sv =====
// Front end of the reprojection pipeline: weight, numerators, magnitudes,
// rounded dividend and overflow check (five register stages).
// Depends on r3d_pkg.
module r3d_front #(
	parameter int MAX_SIDE = r3d_pkg::MAX_SIDE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            pix_vld,
	input  r3d_pkg::pixel_t pix,
	input  r3d_pkg::cfg_t   cfg,
	output logic            vld,
	output r3d_pkg::div_t   dout
);
	import r3d_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1: product and numerators
	logic signed [W_W-1:0]              prod_c;
	logic [NUM_LANES-1:0][N_W-1:0]      num_c;
	logic                               bad_c;
	logic signed [W_W-1:0]              prod_s1;
	logic [NUM_LANES-1:0][N_W-1:0]      num_s1;
	logic                               bad_s1;

	// stage 2: weight
	logic signed [W_W-1:0]              w_s2;
	logic [NUM_LANES-1:0][N_W-1:0]      num_s2;
	logic                               bad_s2;

	// stage 3: magnitudes and signs
	logic [W_W-1:0]                     aw_c;
	logic [NUM_LANES-1:0][N_W-1:0]      nneg_c;
	logic [W_W-1:0]                     aw_s3;
	logic [NUM_LANES-1:0][AN_W-1:0]     an_s3;
	logic [NUM_LANES-1:0]               neg_s3;
	logic                               bad_s3;

	// stage 4: divisor and rounded dividend
	logic [DVS_W-1:0]                   dvs_s4;
	logic [NUM_LANES-1:0][NN_W-1:0]     nn_s4;
	logic [NUM_LANES-1:0]               neg_s4;
	logic                               bad_s4;

	// stage 5: overflow check, divider start
	div_t                               start_c;
	div_t                               div_s5;

	assign prod_c = W_W'($signed(pix.disparity)) * W_W'($signed(cfg.disp_scale));
	assign num_c[LANE_X] = $signed({{(N_W-PIX_W-FRAC_W){1'b0}}, pix.col, {FRAC_W{1'b0}}})
		+ $signed({{(N_W-CFG_W){cfg.x_offset[CFG_W-1]}}, cfg.x_offset});
	assign num_c[LANE_Y] = $signed({{(N_W-PIX_W-FRAC_W){1'b0}}, pix.row, {FRAC_W{1'b0}}})
		+ $signed({{(N_W-CFG_W){cfg.y_offset[CFG_W-1]}}, cfg.y_offset});
	assign num_c[LANE_Z] = {{(N_W-CFG_W){cfg.focal_term[CFG_W-1]}}, cfg.focal_term};
	assign bad_c = (32'(pix.col) >= 32'(MAX_SIDE)) || (32'(pix.row) >= 32'(MAX_SIDE));

	assign aw_c = w_s2[W_W-1] ? (~w_s2 + 1'b1) : w_s2;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			nneg_c[i] = ~num_s2[i] + 1'b1;
		end
	end

	always_comb begin
		start_c.bad = bad_s4;
		start_c.dvs = dvs_s4;
		for (int i = 0; i < NUM_LANES; i++) begin
			start_c.lane[i].rem = {{(DVS_W-HI_W){1'b0}}, nn_s4[i][NN_W-1:Q_W]};
			start_c.lane[i].nq  = nn_s4[i][Q_W-1:0];
			start_c.lane[i].neg = neg_s4[i];
			start_c.lane[i].ovf = {{(DVS_W-HI_W){1'b0}}, nn_s4[i][NN_W-1:Q_W]} >= dvs_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_c;
			num_s1  <= num_c;
			bad_s1  <= bad_c;

			// W = d*scale + offset*16, 20 fraction bits
			w_s2   <= prod_s1 + $signed({{(W_W-CFG_W-DISP_FRAC){cfg.disp_offset[CFG_W-1]}},
				cfg.disp_offset, {DISP_FRAC{1'b0}}});
			num_s2 <= num_s1;
			bad_s2 <= bad_s1;

			aw_s3  <= aw_c;
			bad_s3 <= bad_s2 || (w_s2 == '0);
			for (int i = 0; i < NUM_LANES; i++) begin
				an_s3[i]  <= num_s2[i][N_W-1] ? nneg_c[i][AN_W-1:0] : num_s2[i][AN_W-1:0];
				neg_s3[i] <= num_s2[i][N_W-1] ^ w_s2[W_W-1];
			end

			dvs_s4 <= {aw_s3, 1'b0};
			for (int i = 0; i < NUM_LANES; i++) begin
				nn_s4[i] <= {an_s3[i], {SCALE_SH{1'b0}}} + {{(NN_W-W_W){1'b0}}, aw_s3};
			end
			neg_s4 <= neg_s3;
			bad_s4 <= bad_s3;

			div_s5 <= start_c;
		end
	end

	assign vld  = vld_s5;
	assign dout = div_s5;

endmodule

// ===== hdl/r3d_div_step.sv =====
// One restoring-division stage: resolves one quotient bit in each of the
// three coordinate lanes against the shared divisor. Depends on r3d_pkg.
module r3d_div_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          vld_in,
	input  r3d_pkg::div_t din,
	output logic          vld,
	output r3d_pkg::div_t dout
);
	import r3d_pkg::*;

	logic [NUM_LANES-1:0][DVS_W:0]   trial_c;
	logic [NUM_LANES-1:0][DVS_W-1:0] diff_c;
	logic [NUM_LANES-1:0]            ge_c;
	div_t                            nxt_c;
	logic                            vld_s1;
	div_t                            div_s1;

	// difference is below the divisor whenever it is kept, so its low bits suffice
	always_comb begin
		nxt_c = din;
		for (int i = 0; i < NUM_LANES; i++) begin
			trial_c[i] = {din.lane[i].rem, din.lane[i].nq[Q_W-1]};
			diff_c[i]  = trial_c[i][DVS_W-1:0] - din.dvs;
			ge_c[i]    = trial_c[i] >= {1'b0, din.dvs};
			nxt_c.lane[i].rem = ge_c[i] ? diff_c[i] : trial_c[i][DVS_W-1:0];
			nxt_c.lane[i].nq  = {din.lane[i].nq[Q_W-2:0], ge_c[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s1 <= nxt_c;
		end
	end

	assign vld  = vld_s1;
	assign dout = div_s1;

endmodule

// ===== hdl/r3d_back.sv =====
// Sign, saturation, zero-weight and out-of-range handling, plus the two-entry output
// buffer that decouples the pipeline from the receiver. Depends on r3d_pkg.
module r3d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_in,
	input  r3d_pkg::div_t   din,
	output logic            adv,
	output logic            point_valid,
	input  logic            point_ready,
	output r3d_pkg::point_t point
);
	import r3d_pkg::*;

	localparam int QDEPTH = 2;
	localparam int CNT_W  = $clog2(QDEPTH + 1);
	localparam int PTR_W  = $clog2(QDEPTH);

	logic [NUM_LANES-1:0]            sat_c;
	logic [NUM_LANES-1:0][OUT_W-1:0] val_c;
	point_t                          res_c;

	point_t             buf_q [QDEPTH];
	logic [CNT_W-1:0]   cnt_q;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic               push;
	logic               pop;

	// magnitude 2^47 is still representable when the result is negative
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			if (din.lane[i].neg) begin
				sat_c[i] = din.lane[i].ovf
					|| (din.lane[i].nq[Q_W-1] && (din.lane[i].nq[Q_W-2:0] != '0));
				val_c[i] = sat_c[i] ? OUT_MIN : (~din.lane[i].nq + 1'b1);
			end else begin
				sat_c[i] = din.lane[i].ovf || din.lane[i].nq[Q_W-1];
				val_c[i] = sat_c[i] ? OUT_MAX : din.lane[i].nq;
			end
		end
	end

	always_comb begin
		if (din.bad) begin
			res_c.point_x = '0;
			res_c.point_y = '0;
			res_c.point_z = '0;
			res_c.invalid = 1'b1;
		end else begin
			res_c.point_x = val_c[LANE_X];
			res_c.point_y = val_c[LANE_Y];
			res_c.point_z = val_c[LANE_Z];
			res_c.invalid = |sat_c;
		end
	end

	// pipeline moves only while the buffer has a free slot
	assign adv         = (cnt_q != CNT_W'(QDEPTH));
	assign push        = adv && vld_in;
	assign point_valid = (cnt_q != '0);
	assign pop         = point_valid && point_ready;
	assign point       = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res_c;
		end
	end

endmodule

// ===== hdl/reproject_disparity_to_3d.sv =====
// Top level of the disparity-to-3D reprojection block: Q-matrix registers,
// front end, divider stages and output buffer. Depends on r3d_pkg,
// r3d_front, r3d_div_step and r3d_back.
//
// Usage
//   pixel channel (pixel_valid / pixel_ready / pixel): one disparity pixel
//   with its column and row per transaction.
//   point channel (point_valid / point_ready / point): one 3D point per
//   pixel, in order. x = (col + x_offset)/w, y = (row + y_offset)/w,
//   z = focal_term/w with w = disparity*disp_scale + disp_offset, each a
//   round-to-nearest (ties away from zero) Q32.16 quotient, saturated.
//   invalid is set for zero weight (points forced to 0), a coordinate at or
//   beyond MAX_SIDE (points 0) or any saturated coordinate.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes one
//   Q16.16 term; cfg_ready is always high, unknown indexes are dropped.
//   Write only while no transaction is in flight.
// Timing
//   Throughput one pixel per clock while the output buffer has a free slot.
//   A pixel passes five front-end stages, 48 divider stages (one quotient
//   bit each, all three coordinates in parallel) and one buffer write.
// Reset and stall
//   arst_n clears the pipeline and the buffer and loads the register reset
//   values. When the receiver stalls, the two-entry output buffer fills and
//   pixel_ready drops; the whole pipeline then freezes in place.
module reproject_disparity_to_3d #(
	parameter int MAX_SIDE = r3d_pkg::MAX_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  r3d_pkg::pixel_t               pixel,
	output logic                          point_valid,
	input  logic                          point_ready,
	output r3d_pkg::point_t               point,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [r3d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [r3d_pkg::CFG_W-1:0]     cfg_data
);
	import r3d_pkg::*;

	cfg_t                cfg_q;
	logic                adv;
	logic [DIV_STEPS:0]  div_vld;
	div_t                div_pipe [DIV_STEPS+1];

	// Q-matrix terms; the user must write them only between transactions, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_offset    <= '0;
			cfg_q.y_offset    <= '0;
			cfg_q.focal_term  <= ONE_Q16;
			cfg_q.disp_scale  <= ONE_Q16;
			cfg_q.disp_offset <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_X_OFFSET:    cfg_q.x_offset    <= cfg_data;
				CFG_Y_OFFSET:    cfg_q.y_offset    <= cfg_data;
				CFG_FOCAL_TERM:  cfg_q.focal_term  <= cfg_data;
				CFG_DISP_SCALE:  cfg_q.disp_scale  <= cfg_data;
				CFG_DISP_OFFSET: cfg_q.disp_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	// one enable for every stage, taken from the buffer occupancy register
	assign pixel_ready = adv;

	r3d_front #(
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.pix_vld(pixel_valid),
		.pix    (pixel),
		.cfg    (cfg_q),
		.vld    (div_vld[0]),
		.dout   (div_pipe[0])
	);

	// quotient bits MSB first; stage k resolves bit DIV_STEPS-1-k
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		r3d_div_step u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.vld_in(div_vld[k]),
			.din   (div_pipe[k]),
			.vld   (div_vld[k+1]),
			.dout  (div_pipe[k+1])
		);
	end

	r3d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_in     (div_vld[DIV_STEPS]),
		.din        (div_pipe[DIV_STEPS]),
		.adv        (adv),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point      (point)
	);

	// a frozen pipeline keeps its occupancy exactly
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |=> $stable(div_vld))
		else $error("divider occupancy changed during a stall");

	// input backpressure only while a point is held at the output
	a_ready_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> point_valid)
		else $error("pixel_ready low with empty output buffer");

	// ready drops only after a point went untaken
	a_ready_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pixel_ready) |-> $past(point_valid && !point_ready))
		else $error("pixel_ready fell without an output stall");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for reproject_disparity_to_3d: directed table, then random
// phases in several idling modes; each point checked by typed value or local predictor.
// Depends on r3d_pkg and the RTL under hdl/.
module testbench;
	import r3d_pkg::*;

	// One directed row: either a register write or a pixel, with an optional
	// typed-in expected point.
	typedef struct {
		bit                 is_write;
		cfg_idx_t           idx;
		logic [CFG_W-1:0]   data;
		pixel_t             px;
		bit                 typed;
		point_t             want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic pixel_valid;
	logic pixel_ready;
	pixel_t pixel;
	logic point_valid;
	logic point_ready;
	point_t point;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	cfg_t q_terms;               // local copy of the Q-matrix registers
	point_t pending_points[$];   // expected points, oldest first
	stim_row_t directed_rows[$];
	int err_count = 0;
	int gap_pct = 0;             // sender idle chance per cycle, percent
	int stall_pct = 0;           // receiver stall chance per cycle, percent

	reproject_disparity_to_3d dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel(pixel),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop in case the pipeline hangs.
	initial begin
		#4_000_000;
		$display("reproject_disparity_to_3d regression: fail");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Rounded num * 2^20 / wgt, ties away from zero, clamped to 48 bits.
	// wgt is nonzero here. Exactly -2^47 is representable and not a clamp.
	function automatic logic signed [OUT_W-1:0] round_quotient(input longint num,
			input longint wgt, inout bit sat);
		longint unsigned an, aw, q;
		logic [63:0] neg_q;
		logic signed [OUT_W-1:0] res;
		bit neg;
		neg = (num < 0) != (wgt < 0);
		an = (num < 0) ? -num : num;
		aw = (wgt < 0) ? -wgt : wgt;
		// doubled dividend plus |w| gives round-half-up on the magnitude
		q = ((an << 21) + aw) / (aw << 1);
		if (!neg) begin
			if (q > 64'(OUT_MAX)) begin
				sat = 1'b1;
				res = OUT_MAX;
			end else begin
				res = q[OUT_W-1:0];
			end
		end else begin
			if (q > 64'(OUT_MAX) + 64'd1) begin
				sat = 1'b1;
				res = OUT_MIN;
			end else begin
				neg_q = -q;
				res = neg_q[OUT_W-1:0];
			end
		end
		return res;
	endfunction

	// Point for one pixel under the current register copy.
	function automatic point_t reproject_pixel(input pixel_t p);
		longint d, wgt, nx, ny, nz;
		point_t r;
		bit sat;
		d = longint'($signed(p.disparity));
		// weight carries 20 fraction bits: Q12.4 times Q16.16, offset lifted by 16
		wgt = d * longint'($signed(q_terms.disp_scale))
			+ longint'($signed(q_terms.disp_offset)) * 16;
		nx = longint'(p.col) * 65536 + longint'($signed(q_terms.x_offset));
		ny = longint'(p.row) * 65536 + longint'($signed(q_terms.y_offset));
		nz = longint'($signed(q_terms.focal_term));
		r = '0;
		sat = 1'b0;
		// col/row never reach MAX_SIDE with 12-bit fields at the default size
		if (wgt == 0) begin
			r.invalid = 1'b1;
		end else begin
			r.point_x = round_quotient(nx, wgt, sat);
			r.point_y = round_quotient(ny, wgt, sat);
			r.point_z = round_quotient(nz, wgt, sat);
			r.invalid = sat;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(input string field, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		err_count++;
		$display("mismatch %s at %0t: got %h want %h", field, $time, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && point_valid && point_ready) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected point", point.point_x, '0);
			end else begin
				automatic point_t want = pending_points.pop_front();
				if (point.point_x !== want.point_x)
					report_mismatch("point_x", point.point_x, want.point_x);
				if (point.point_y !== want.point_y)
					report_mismatch("point_y", point.point_y, want.point_y);
				if (point.point_z !== want.point_z)
					report_mismatch("point_z", point.point_z, want.point_z);
				if (point.invalid !== want.invalid)
					report_mismatch("invalid", OUT_W'(point.invalid), OUT_W'(want.invalid));
			end
		end
	end

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk)
		point_ready <= ($urandom_range(99) >= stall_pct);

	// ---------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------

	task automatic wait_for_drain();
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	// Register write: only once every point in flight has come out. Valid is
	// left high so back-to-back writes keep one assignment per step.
	task automatic write_term(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		if (pixel_valid)
			pixel_valid <= 1'b0;
		wait_for_drain();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_X_OFFSET:    q_terms.x_offset = data;
			CFG_Y_OFFSET:    q_terms.y_offset = data;
			CFG_FOCAL_TERM:  q_terms.focal_term = data;
			CFG_DISP_SCALE:  q_terms.disp_scale = data;
			CFG_DISP_OFFSET: q_terms.disp_offset = data;
			default: ;
		endcase
	endtask

	// One pixel transaction, with random sender gaps in front of it. The
	// expectation is queued at the accepting edge.
	task automatic send_pixel(input pixel_t p, input bit typed, input point_t want);
		if (cfg_valid)
			cfg_valid <= 1'b0;
		while ($urandom_range(99) < gap_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		do @(posedge clk); while (!pixel_ready);
		pending_points = {pending_points, (typed ? want : reproject_pixel(p))};
	endtask

	// ---------------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------------

	function automatic stim_row_t blank_row();
		stim_row_t s;
		s.is_write = 1'b0;
		s.idx = CFG_X_OFFSET;
		s.data = '0;
		s.px = '0;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic pixel_t make_pixel(input int d, input int c, input int r);
		pixel_t p;
		p.disparity = DISP_W'(d);
		p.col = PIX_W'(c);
		p.row = PIX_W'(r);
		return p;
	endfunction

	function automatic void add_write(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		stim_row_t s;
		s = blank_row();
		s.is_write = 1'b1;
		s.idx = idx;
		s.data = data;
		directed_rows = {directed_rows, s};
	endfunction

	function automatic void add_pixel(input int d, input int c, input int r);
		stim_row_t s;
		s = blank_row();
		s.px = make_pixel(d, c, r);
		directed_rows = {directed_rows, s};
	endfunction

	function automatic void add_known(input int d, input int c, input int r,
			input logic [OUT_W-1:0] x, input logic [OUT_W-1:0] y,
			input logic [OUT_W-1:0] z, input bit inv);
		stim_row_t s;
		s = blank_row();
		s.px = make_pixel(d, c, r);
		s.typed = 1'b1;
		s.want.point_x = x;
		s.want.point_y = y;
		s.want.point_z = z;
		s.want.invalid = inv;
		directed_rows = {directed_rows, s};
	endfunction

	function automatic void build_directed();
		// Reset terms: w = disparity * 1.0, so a disparity of 16 (1.0) gives
		// plain pixel coordinates and z of 1.0.
		add_known(16, 5, 7, 48'd327680, 48'd458752, 48'd65536, 1'b0);
		add_known(0, 4095, 4095, '0, '0, '0, 1'b1);           // zero weight
		add_known(-16, 4095, 4095, -48'sd268369920, -48'sd268369920, -48'sd65536, 1'b0);
		add_known(1, 4095, 0, 48'd4293918720, '0, 48'd1048576, 1'b0);
		add_pixel(32767, 0, 4095);
		add_pixel(-32768, 4095, 0);
		add_pixel(3, 1, 2);
		// z = 1/(2d): exact halves round away from zero
		add_write(CFG_FOCAL_TERM, 32'd1);
		add_write(CFG_DISP_SCALE, 32'h0020_0000);
		add_known(1, 0, 0, '0, '0, 48'd1, 1'b0);
		add_known(-1, 0, 0, '0, '0, -48'sd1, 1'b0);
		add_pixel(3, 0, 0);
		// weight of one: large numerators clamp both ways
		add_write(CFG_DISP_SCALE, 32'd1);
		add_write(CFG_FOCAL_TERM, 32'h7FFF_FFFF);
		add_known(1, 0, 0, '0, '0, OUT_MAX, 1'b1);
		add_known(-1, 0, 0, '0, '0, OUT_MIN, 1'b1);
		add_pixel(1, 4095, 4095);
		// z of exactly +2^47 clamps, exactly -2^47 fits
		add_write(CFG_FOCAL_TERM, 32'h0800_0000);
		add_known(1, 0, 0, '0, '0, OUT_MAX, 1'b1);
		add_known(-1, 0, 0, '0, '0, OUT_MIN, 1'b0);
		// nonzero disparity cancelled by the offset term
		add_write(CFG_DISP_SCALE, 32'd16);
		add_write(CFG_DISP_OFFSET, 32'hFFFF_FFFF);
		add_known(1, 9, 9, '0, '0, '0, 1'b1);
		add_pixel(2, 9, 9);
		// register extremes
		add_write(CFG_X_OFFSET, 32'h8000_0000);
		add_write(CFG_Y_OFFSET, 32'h7FFF_FFFF);
		add_write(CFG_FOCAL_TERM, 32'h8000_0000);
		add_write(CFG_DISP_SCALE, 32'h8000_0000);
		add_write(CFG_DISP_OFFSET, 32'h7FFF_FFFF);
		add_pixel(32767, 4095, 4095);
		add_pixel(-32768, 0, 0);
		add_pixel(0, 0, 0);
		add_write(CFG_FOCAL_TERM, 32'h7FFF_FFFF);
		add_write(CFG_DISP_SCALE, 32'h7FFF_FFFF);
		add_write(CFG_DISP_OFFSET, 32'h8000_0000);
		add_pixel(-32768, 4095, 0);
		add_pixel(32767, 0, 4095);
	endfunction

	// ---------------------------------------------------------------------
	// Random stimulus
	// ---------------------------------------------------------------------

	// Q-matrix term: extremes, zero, small camera-like values, or anything.
	function automatic logic [CFG_W-1:0] pick_term();
		logic [CFG_W-1:0] v;
		case ($urandom_range(7))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = '0;
			3, 4: v = CFG_W'($urandom_range(2 * 1048576) - 1048576);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic pixel_t pick_pixel();
		pixel_t p;
		case ($urandom_range(9))
			0: p.disparity = '0;
			1: p.disparity = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			2, 3, 4: p.disparity = DISP_W'($urandom_range(128) - 64);
			default: p.disparity = DISP_W'($urandom);
		endcase
		p.col = PIX_W'($urandom);
		p.row = PIX_W'($urandom);
		return p;
	endfunction

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		point_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_X_OFFSET;
		cfg_data = '0;
		q_terms.x_offset = '0;
		q_terms.y_offset = '0;
		q_terms.focal_term = ONE_Q16;
		q_terms.disp_scale = ONE_Q16;
		q_terms.disp_offset = '0;
		build_directed();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows, no idling.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write)
				write_term(directed_rows[i].idx, directed_rows[i].data);
			else
				send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
		end

		// Random phases: fresh terms each, cycling through the idling modes
		// (none, sender idle, receiver stall, both).
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 53; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 53; end
				default: begin gap_pct = 30; stall_pct = 30; end
			endcase
			write_term(CFG_X_OFFSET, pick_term());
			write_term(CFG_Y_OFFSET, pick_term());
			write_term(CFG_FOCAL_TERM, pick_term());
			write_term(CFG_DISP_SCALE, pick_term());
			write_term(CFG_DISP_OFFSET, pick_term());
			repeat (66)
				send_pixel(pick_pixel(), 1'b0, '0);
		end

		pixel_valid <= 1'b0;
		wait_for_drain();
		// anything stray from the pipeline shows up well within this wait
		repeat (80) @(posedge clk);
		if (err_count == 0)
			$display("reproject_disparity_to_3d regression: pass");
		else
			$display("reproject_disparity_to_3d regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/r3d_pkg.sv
hdl/r3d_front.sv
hdl/r3d_div_step.sv
hdl/r3d_back.sv
hdl/reproject_disparity_to_3d.sv
verif/testbench.sv
